### hw/rtl/erm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg
// Shared widths, reset values, register indexes and mode codes of the event rate meter.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int VAL_W     = 48;
    localparam int COUNT_W   = 32;
    localparam int MODE_W    = 2;
    localparam int ALPHA_W   = 17;
    localparam int IVL_W     = 12;
    localparam int TICKS_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;

    localparam int ALPHA_FRAC = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(5396);
    localparam logic [IVL_W-1:0]   IVL_RESET   = IVL_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IVL   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_EWMA = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CUM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INST = 2'd2;

endpackage

### hw/rtl/event_rate_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_rate_meter
// Event rate meter: exponential, cumulative or instant rate of events per
// second, updated on tick words through one bit-serial divider and one
// shift-add multiplier under a small sequencer.
//
//   channel | dir | tdata              | tuser | handshake
//   s_      | in  | count[31:0]        | tick  | tvalid/tready
//   m_      | out | rate[47:0]         | -     | tvalid/tready
//   cfg_    | in  | wdata[16:0]        | -     | wr_en, index (no wait)
//
// A word without tick goes straight to S_DONE. A tick word runs the interval
// rate division, then the multiplier (exponential) or a second division
// (cumulative), one quotient or multiplier bit per cycle. Reset (aresetn,
// synchronous) clears state, pending, rate, started, ticks and m_tvalid; the
// config returns to mode 0, alpha 5396, interval 5. s_tready is high in idle
// only; a finished rate waits in m_tdata while the next word is accepted.
// ----------------------------------------------------------------------------
module event_rate_meter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [erm_pkg::COUNT_W-1:0]         s_tdata,   // [31:0] count
    input  logic                                s_tuser,   // [0] tick

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [erm_pkg::VAL_W-1:0]           m_tdata,   // [47:0] rate

    input  logic                                cfg_wr_en,
    input  logic [erm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [erm_pkg::CFG_W-1:0]           cfg_wdata
);
    import erm_pkg::*;

    localparam int DW    = VAL_W + FRAC_BITS;
    localparam int QW    = VAL_W + 1;
    localparam int DVS_W = TICKS_W + 1;
    localparam int MUL_W = QW + ALPHA_W;
    localparam int CNT_W = $clog2(DW + 1);

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [MUL_W-1:0] ROUND_HALF = MUL_W'(1) << (ALPHA_FRAC - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DIV_INST = 7'b0000010,
        S_INST_FIN = 7'b0000100,
        S_DIV_CUM  = 7'b0001000,
        S_MUL      = 7'b0010000,
        S_APPLY    = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [VAL_W-1:0]       pending_reg, pending_next;
    logic [VAL_W-1:0]       rate_reg, rate_next;
    logic                   started_reg, started_next;
    logic [TICKS_W-1:0]     ticks_reg, ticks_next;
    logic [DW-1:0]          dvd_reg, dvd_next;
    logic [DVS_W-1:0]       dvs_reg, dvs_next;
    logic [DVS_W-1:0]       rem_reg, rem_next;
    logic [QW-1:0]          quo_reg, quo_next;
    logic                   big_reg, big_next;
    logic                   neg_reg, neg_next;
    logic                   cum_reg, cum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [MUL_W-1:0]       acc_reg, acc_next;
    logic                   m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]       m_data_reg, m_data_next;

    logic [MODE_W-1:0]      mode_reg;
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [IVL_W-1:0]       ivl_reg;

    // shared datapath
    logic [DVS_W:0]         rem_sh;
    logic                   div_ge;
    logic [DVS_W:0]         rem_sub;
    logic [VAL_W-1:0]       pend_mag;
    logic [QW-1:0]          lim;
    logic [QW-1:0]          inst_mag;
    logic [QW-1:0]          inst_w;
    logic [QW-1:0]          diff;
    logic [QW-1:0]          diff_mag;
    logic [ALPHA_W-1:0]     alpha_eff;
    logic [MUL_W-1:0]       acc_rnd;
    logic [QW-1:0]          step;
    logic [QW-1:0]          rate_upd;
    logic [QW-1:0]          pend_sum;
    logic                   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign div_ge  = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    assign pend_mag = pending_reg[VAL_W-1] ? (VAL_W'(0) - pending_reg) : pending_reg;
    assign lim      = neg_reg ? {1'b0, VAL_MIN} : {1'b0, VAL_MAX};
    assign inst_mag = (big_reg || (quo_reg > lim)) ? lim : quo_reg;
    assign inst_w   = neg_reg ? (QW'(0) - inst_mag) : inst_mag;
    assign diff     = inst_w - {rate_reg[VAL_W-1], rate_reg};
    assign diff_mag = diff[QW-1] ? (QW'(0) - diff) : diff;
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    assign acc_rnd  = acc_reg + ROUND_HALF;
    assign step     = cum_reg ? quo_reg : acc_rnd[ALPHA_FRAC +: QW];
    assign rate_upd = neg_reg ? ({rate_reg[VAL_W-1], rate_reg} - step)
                              : ({rate_reg[VAL_W-1], rate_reg} + step);
    assign pend_sum = {pending_reg[VAL_W-1], pending_reg}
                    + QW'(signed'(count_reg));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        rate_next    = rate_reg;
        started_next = started_reg;
        ticks_next   = ticks_reg;
        dvd_next     = dvd_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        big_next     = big_reg;
        neg_next     = neg_reg;
        cum_next     = cum_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    count_next = s_tdata;
                    if (s_tuser) begin
                        dvd_next   = DW'(pend_mag) << FRAC_BITS;
                        dvs_next   = (ivl_reg == '0) ? DVS_W'(1) : DVS_W'(ivl_reg);
                        rem_next   = '0;
                        quo_next   = '0;
                        big_next   = 1'b0;
                        neg_next   = pending_reg[VAL_W-1];
                        cnt_next   = CNT_W'(DW);
                        state_next = S_DIV_INST;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV_INST, S_DIV_CUM: begin
                rem_next = div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                quo_next = {quo_reg[QW-2:0], div_ge};
                big_next = big_reg | quo_reg[QW-1];
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = (state_reg == S_DIV_INST) ? S_INST_FIN : S_APPLY;
                end
            end
            S_INST_FIN: begin
                pending_next = '0;
                neg_next     = diff[QW-1];
                rem_next     = '0;
                quo_next     = '0;
                acc_next     = '0;
                if (mode_reg == MODE_EWMA) begin
                    cum_next = 1'b0;
                    if (!started_reg || alpha_eff == ALPHA_ONE) begin
                        rate_next    = inst_w[VAL_W-1:0];
                        started_next = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        dvd_next   = DW'(diff_mag);
                        quo_next   = QW'(alpha_eff);
                        cnt_next   = CNT_W'(ALPHA_W);
                        state_next = S_MUL;
                    end
                end else if (mode_reg == MODE_CUM) begin
                    cum_next   = 1'b1;
                    big_next   = 1'b0;
                    dvd_next   = DW'(diff_mag) << (DW - QW);
                    dvs_next   = DVS_W'(ticks_reg) + DVS_W'(1);
                    cnt_next   = CNT_W'(QW);
                    state_next = S_DIV_CUM;
                end else begin
                    rate_next  = inst_w[VAL_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_MUL: begin
                acc_next = (acc_reg << 1)
                         + (quo_reg[ALPHA_W-1] ? MUL_W'(dvd_reg[QW-1:0]) : MUL_W'(0));
                quo_next = quo_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                rate_next = rate_upd[VAL_W-1:0];
                if (cum_reg && ticks_reg != '1) begin
                    ticks_next = ticks_reg + TICKS_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    if (pend_sum[QW-1] != pend_sum[VAL_W-1]) begin
                        pending_next = pend_sum[QW-1] ? VAL_MIN : VAL_MAX;
                    end else begin
                        pending_next = pend_sum[VAL_W-1:0];
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = rate_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pending_reg <= '0;
            rate_reg    <= '0;
            started_reg <= 1'b0;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            rate_reg    <= rate_next;
            started_reg <= started_next;
            ticks_reg   <= ticks_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg  <= count_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        big_reg    <= big_next;
        neg_reg    <= neg_next;
        cum_reg    <= cum_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_EWMA;
            alpha_reg <= ALPHA_RESET;
            ivl_reg   <= IVL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_wdata[MODE_W-1:0];
                REG_ALPHA: alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                REG_IVL:   ivl_reg   <= cfg_wdata[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
